/* design/rwr_pkg.sv */
// Package for the reorder window receiver: command, status and register codes,
// word widths and default parameter values. No dependencies.
`default_nettype none

package rwr_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned DATA_BITS_DEF = 32;
  localparam int unsigned SEQ_W         = 32;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned WIN_W         = 5;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

  typedef enum logic [1:0] {
    CMD_STORE   = 2'd0,
    CMD_POP     = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OUT_WIN = 2'd1,
    ST_MISSING = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_SEQ   = 1'b0,
    CFG_WINDOW_SIZE = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

/* design/rwr_if.sv */
// Channel interfaces of the reorder window receiver: command input, result
// output and register write. Depends on rwr_pkg.
`default_nettype none

interface rwr_in_if import rwr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [SEQ_W-1:0]  seq;
  logic [WORD_W-1:0] packet_data;

  modport source (output valid, command, seq, packet_data, input ready);
  modport sink   (input valid, command, seq, packet_data, output ready);
endinterface

interface rwr_out_if import rwr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [WORD_W-1:0] out_data;
  logic [SEQ_W-1:0]  out_seq;
  logic              gap_flag;
  logic [SEQ_W-1:0]  gap_seq;

  modport source (output valid, status, out_data, out_seq, gap_flag, gap_seq, input ready);
  modport sink   (input valid, status, out_data, out_seq, gap_flag, gap_seq, output ready);
endinterface

interface rwr_cfg_if import rwr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/reorder_window_receiver.sv */
// Reorder window receiver top: slot valid bits, expected number, data RAM and the
// result register. Depends on rwr_pkg, rwr_if, rwr_ram and rwr_mod_unit.
// A result word is offered in the cycle after its command word is accepted.
// Throughput: 1 command word per cycle; a result word left waiting stalls input.
// Register writes are taken every cycle and apply from the next command word.
// Reset: expected number 0, all slots empty, window size 16, output empty.
`default_nettype none

module reorder_window_receiver import rwr_pkg::*; #(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rwr_in_if.sink   in_i,
  rwr_out_if.source out_o,
  rwr_cfg_if.sink  cfg_i
);

  localparam int unsigned IDX_W    = $clog2(SLOTS);
  // slot offset picked up when a sequence number wraps past 2^32
  localparam int unsigned WRAP_REM = 32'((64'd1 << SEQ_W) % 64'(SLOTS));
  localparam int unsigned WRAP_ADJ = (SLOTS - WRAP_REM) % SLOTS;

  // configuration
  logic [SEQ_W-1:0] start_seq_q;
  logic [WIN_W-1:0] window_size_q;
  logic             cfg_fire;
  logic             seq_load;
  logic [IDX_W-1:0] init_slot;

  // window state
  logic [SEQ_W-1:0] expected_q, expected_d;
  logic [IDX_W-1:0] exp_slot_q, exp_slot_d;
  logic [SLOTS-1:0] valid_q, valid_d;

  // output register
  logic             out_valid_q;
  logic             hit_q;
  logic [1:0]       status_q;
  logic [SEQ_W-1:0] out_seq_q;
  logic             gap_flag_q;
  logic [SEQ_W-1:0] gap_seq_q;

  // step logic
  logic             in_fire;
  logic             out_free;
  cmd_e             cmd;
  logic [SEQ_W-1:0] diff;
  logic [SEQ_W-1:0] win_eff;
  logic             in_win;
  logic             seq_wrap;
  logic [IDX_W+1:0] slot_sum;
  logic [IDX_W-1:0] store_slot;
  logic             pop_hit;
  logic             store_ok;
  logic             gap;
  status_e          status_d;

  logic [DATA_BITS-1:0] ram_wdata;
  logic [DATA_BITS-1:0] ram_rdata;
  logic [63:0]          wide_wdata;
  logic [63:0]          wide_rdata;

  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  assign seq_load    = cfg_fire && (cfg_i.index == CFG_START_SEQ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_seq_q   <= '0;
      window_size_q <= WIN_RESET;
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_START_SEQ:   start_seq_q   <= cfg_i.data[SEQ_W-1:0];
        CFG_WINDOW_SIZE: window_size_q <= cfg_i.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  rwr_mod_unit #(
    .SLOTS (SLOTS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (seq_load),
    .value_i (cfg_i.data[SEQ_W-1:0]),
    .rem_o   (init_slot)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = out_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cmd         = cmd_e'(in_i.command);

  assign diff     = in_i.seq - expected_q;
  assign win_eff  = (32'(window_size_q) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(window_size_q);
  assign in_win   = diff < win_eff;
  assign pop_hit  = valid_q[exp_slot_q];
  assign seq_wrap = in_i.seq < expected_q;

  always_comb begin
    slot_sum = (IDX_W+2)'(exp_slot_q) + (IDX_W+2)'(diff[IDX_W-1:0]);
    if (seq_wrap) begin
      slot_sum = slot_sum + (IDX_W+2)'(WRAP_ADJ);
    end
    if (slot_sum >= (IDX_W+2)'(SLOTS)) begin
      slot_sum = slot_sum - (IDX_W+2)'(SLOTS);
    end
    if (slot_sum >= (IDX_W+2)'(SLOTS)) begin
      slot_sum = slot_sum - (IDX_W+2)'(SLOTS);
    end
    store_slot = slot_sum[IDX_W-1:0];
  end

  always_comb begin
    expected_d = expected_q;
    exp_slot_d = exp_slot_q;
    valid_d    = valid_q;
    status_d   = ST_DONE;
    store_ok   = 1'b0;
    case (cmd)
      CMD_STORE: begin
        if (in_win) begin
          store_ok            = 1'b1;
          valid_d[store_slot] = 1'b1;
        end else begin
          status_d = ST_OUT_WIN;
        end
      end
      CMD_POP: begin
        if (pop_hit) begin
          valid_d[exp_slot_q] = 1'b0;
          expected_d          = expected_q + 1'b1;
          if ((expected_q == '1) || (exp_slot_q == IDX_W'(SLOTS - 1))) begin
            exp_slot_d = '0;
          end else begin
            exp_slot_d = exp_slot_q + 1'b1;
          end
        end else begin
          status_d = ST_MISSING;
        end
      end
      CMD_RESTART: begin
        expected_d = start_seq_q;
        exp_slot_d = init_slot;
        valid_d    = '0;
      end
      default: ;
    endcase
    gap = !valid_d[exp_slot_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q  <= '0;
      exp_slot_q  <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        expected_q <= expected_d;
        exp_slot_q <= exp_slot_d;
        valid_q    <= valid_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hit_q      <= (cmd == CMD_POP) && pop_hit;
      status_q   <= status_d;
      out_seq_q  <= ((cmd == CMD_POP) && pop_hit) ? expected_q : '0;
      gap_flag_q <= gap;
      gap_seq_q  <= gap ? expected_d : '0;
    end
  end

  assign wide_wdata = 64'(in_i.packet_data);
  assign ram_wdata  = wide_wdata[DATA_BITS-1:0];

  rwr_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (cmd == CMD_STORE) && store_ok),
    .waddr_i (store_slot),
    .wdata_i (ram_wdata),
    .re_i    (in_fire && (cmd == CMD_POP) && pop_hit),
    .raddr_i (exp_slot_q),
    .rdata_o (ram_rdata)
  );

  assign wide_rdata     = 64'(ram_rdata);
  assign out_o.valid    = out_valid_q;
  assign out_o.status   = status_q;
  assign out_o.out_data = hit_q ? wide_rdata[WORD_W-1:0] : '0;
  assign out_o.out_seq  = out_seq_q;
  assign out_o.gap_flag = gap_flag_q;
  assign out_o.gap_seq  = gap_seq_q;

  a_pop_hit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd == CMD_POP) && pop_hit) |=> (out_valid_q && hit_q
      && (status_q == ST_DONE)))
    else $error("pop of a held slot did not give a delivered word");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd == CMD_RESTART)) |=>
      (valid_q == '0) && (expected_q == $past(start_seq_q)))
    else $error("restart left slots marked or expected number wrong");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(exp_slot_q) < 32'(SLOTS))
    else $error("expected slot index out of range");

  a_pop_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd == CMD_POP) && pop_hit) |=>
      (expected_q == $past(expected_q) + 1'b1) && !valid_q[$past(exp_slot_q)])
    else $error("pop did not advance the window");

endmodule

`default_nettype wire

/* design/rwr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rwr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/rwr_mod_unit.sv */
// Remainder of a 32-bit word by the slot count, by reciprocal multiplication;
// the low quotient bits are registered when the word is loaded. Depends on rwr_pkg.
`default_nettype none

module rwr_mod_unit import rwr_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire logic [SEQ_W-1:0]         value_i,
  output logic      [$clog2(SLOTS)-1:0] rem_o
);

  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned SHIFT   = SEQ_W + IDX_W;
  localparam int unsigned RECIP_W = SEQ_W + 1;
  localparam int unsigned PROD_W  = SEQ_W + RECIP_W;
  // ceil(2^SHIFT / SLOTS) gives the exact quotient for every 32-bit word
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_FULL[RECIP_W-1:0];
  localparam logic [IDX_W-1:0]   SLOTS_LO = IDX_W'(SLOTS);

  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  quo_lo_q, quo_lo_d;
  logic [IDX_W-1:0]  val_lo_q, val_lo_d;
  logic [IDX_W-1:0]  quo_mul;

  assign prod = PROD_W'(value_i) * PROD_W'(RECIP);

  always_comb begin
    quo_lo_d = quo_lo_q;
    val_lo_d = val_lo_q;
    if (load_i) begin
      quo_lo_d = prod[SHIFT +: IDX_W];
      val_lo_d = value_i[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_lo_q <= '0;
      val_lo_q <= '0;
    end else begin
      quo_lo_q <= quo_lo_d;
      val_lo_q <= val_lo_d;
    end
  end

  // the remainder is below the slot count, so the low bits suffice
  assign quo_mul = IDX_W'(quo_lo_q * SLOTS_LO);
  assign rem_o   = val_lo_q - quo_mul;

endmodule

`default_nettype wire
